/* hdl/bdq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the bounded double-ended queue core.
// No dependencies; every other file refers to it by scoped names.
package bdq_pkg;

   localparam int MAX_DEPTH = 1024;
   localparam int IDX_W     = $clog2(MAX_DEPTH);
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
   localparam int CAP_W     = 11;
   localparam int WORD_W    = 32;
   localparam int OP_W      = 3;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1024);
   localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_QUERY      = 3'd4
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic                     success;
      logic signed [WORD_W-1:0] front_word;
      logic signed [WORD_W-1:0] rear_word;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [WORD_W-1:0] data;
   } ring_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] front_addr;
      logic [IDX_W-1:0] rear_addr;
   } ring_rd_type;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(MAX_DEPTH - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(MAX_DEPTH - 1) : i - IDX_W'(1);
   endfunction

endpackage

/* hdl/bdq_ring.sv */
`timescale 1ns / 1ps
// Ring storage: one write port, two registered read ports with write forwarding.
// Depends on bdq_pkg.
module bdq_ring (
   input  logic                                clock,
   input  bdq_pkg::ring_wr_type                wr,
   input  bdq_pkg::ring_rd_type                rd,
   output logic [bdq_pkg::WORD_W-1:0]          front_data,
   output logic [bdq_pkg::WORD_W-1:0]          rear_data
);

   logic [bdq_pkg::WORD_W-1:0] mem [bdq_pkg::MAX_DEPTH];
   logic [bdq_pkg::WORD_W-1:0] front_data_ff;
   logic [bdq_pkg::WORD_W-1:0] rear_data_ff;
   logic                       front_fwd;
   logic                       rear_fwd;

   assign front_fwd = wr.en && (wr.addr == rd.front_addr);
   assign rear_fwd  = wr.en && (wr.addr == rd.rear_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // a word written this cycle wins over the old array contents
   always_ff @(posedge clock) begin
      if (rd.en) begin
         front_data_ff <= front_fwd ? wr.data : mem[rd.front_addr];
         rear_data_ff  <= rear_fwd  ? wr.data : mem[rd.rear_addr];
      end
   end

   assign front_data = front_data_ff;
   assign rear_data  = rear_data_ff;

endmodule

/* hdl/bounded_double_ended_queue_core.sv */
`timescale 1ns / 1ps
// Top level of the bounded double-ended queue: index/count update, result staging.
// Depends on bdq_pkg and bdq_ring.
//
//  channel | direction | handshake          | word
//  req_    | in        | req_valid/req_stall| bdq_pkg::req_type
//  rsp_    | out       | rsp_valid/rsp_stall| bdq_pkg::rsp_type
//  csr_    | in        | csr_valid/csr_ready| capacity, 11 bits
//
// One word is accepted per cycle while req_stall is low; its result is presented
// from the output register, loaded from the ring read registered at acceptance.
// Reset clears head, tail and count and sets capacity to 1024; no clearing pass.
// The result stage holds two words, so one result may wait under rsp_stall
// while the next word is accepted; req_stall rises only when both are held.
module bounded_double_ended_queue_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bdq_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bdq_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bdq_pkg::CAP_W-1:0]    csr_wdata
);

   logic [bdq_pkg::IDX_W-1:0] head_ff, head_in;
   logic [bdq_pkg::IDX_W-1:0] tail_ff, tail_in;
   logic [bdq_pkg::CNT_W-1:0] count_ff, count_in;
   logic [bdq_pkg::CAP_W-1:0] capacity_ff;
   logic [bdq_pkg::CNT_W-1:0] eff_cap;

   logic                      a_valid_ff, a_valid_in;
   logic                      a_success_ff;
   logic                      a_empty_ff;
   logic                      a_full_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   bdq_pkg::rsp_type          rsp_data_ff;

   logic                      accept;
   logic                      b_load;
   logic                      ok;
   logic                      room;
   logic                      any;
   bdq_pkg::ring_wr_type      wr;
   bdq_pkg::ring_rd_type      rd;
   logic [bdq_pkg::WORD_W-1:0] front_data;
   logic [bdq_pkg::WORD_W-1:0] rear_data;

   // capacity above the ring depth saturates at the depth
   assign eff_cap = (32'(capacity_ff) > 32'(bdq_pkg::MAX_DEPTH))
                    ? bdq_pkg::CNT_W'(bdq_pkg::MAX_DEPTH)
                    : bdq_pkg::CNT_W'(capacity_ff);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bdq_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_wdata;
      end
   end

   // two-word result stage: A holds the RAM read, the output register holds B
   assign b_load     = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = a_valid_ff && !b_load;
   assign accept     = req_valid && !req_stall;
   assign a_valid_in = accept || (a_valid_ff && !b_load);
   assign rsp_valid_in = b_load || (rsp_valid_ff && rsp_stall);

   assign room = count_ff < eff_cap;
   assign any  = count_ff != '0;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ok       = 1'b0;
      wr.en    = 1'b0;
      wr.addr  = tail_ff;
      wr.data  = req_data.push_value;
      case (req_data.opcode)
         bdq_pkg::OP_PUSH_FRONT: begin
            if (room) begin
               head_in  = bdq_pkg::idx_dec(head_ff);
               count_in = count_ff + bdq_pkg::CNT_W'(1);
               wr.en    = accept;
               wr.addr  = head_in;
               ok       = 1'b1;
            end
         end
         bdq_pkg::OP_PUSH_BACK: begin
            if (room) begin
               tail_in  = bdq_pkg::idx_inc(tail_ff);
               count_in = count_ff + bdq_pkg::CNT_W'(1);
               wr.en    = accept;
               wr.addr  = tail_ff;
               ok       = 1'b1;
            end
         end
         bdq_pkg::OP_POP_FRONT: begin
            if (any) begin
               head_in  = bdq_pkg::idx_inc(head_ff);
               count_in = count_ff - bdq_pkg::CNT_W'(1);
               ok       = 1'b1;
            end
         end
         bdq_pkg::OP_POP_BACK: begin
            if (any) begin
               tail_in  = bdq_pkg::idx_dec(tail_ff);
               count_in = count_ff - bdq_pkg::CNT_W'(1);
               ok       = 1'b1;
            end
         end
         bdq_pkg::OP_QUERY: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      rd.en         = accept;
      rd.front_addr = head_in;
      rd.rear_addr  = bdq_pkg::idx_dec(tail_in);
   end

   bdq_ring u_ring (
      .clock      (clock),
      .wr         (wr),
      .rd         (rd),
      .front_data (front_data),
      .rear_data  (rear_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_success_ff <= ok;
         a_empty_ff   <= count_in == '0;
         a_full_ff    <= count_in >= eff_cap;
      end
   end

   // an empty queue reports -1 at both ends
   always_ff @(posedge clock) begin
      if (b_load) begin
         rsp_data_ff.success    <= a_success_ff;
         rsp_data_ff.front_word <= a_empty_ff ? bdq_pkg::EMPTY_WORD : front_data;
         rsp_data_ff.rear_word  <= a_empty_ff ? bdq_pkg::EMPTY_WORD : rear_data;
         rsp_data_ff.is_empty   <= a_empty_ff;
         rsp_data_ff.is_full    <= a_full_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/bdq_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the bounded double-ended queue core, bound to the top.
// Depends on bdq_pkg and bounded_double_ended_queue_core.
module bdq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input bdq_pkg::rsp_type          rsp_data
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result word changed");

   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         (rsp_data.front_word == bdq_pkg::EMPTY_WORD) &&
         (rsp_data.rear_word == bdq_pkg::EMPTY_WORD))
      else $error("empty queue reports a stored word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word presented straight after reset");

   // the input stalls only behind a held result word
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with the result stage free");

endmodule

bind bounded_double_ended_queue_core bdq_checker u_bdq_checker (.*);
